### rtl/dmf_pkg.sv
// dmf_pkg: shared types and constants for the max-flow / min-cut block.
// Holds the payload structs, stack frame layout, config register indexes and
// the sequencer state enum. No dependencies.
package dmf_pkg;

  localparam int VIDX_W     = 6;   // vertex index width
  localparam int NCNT_W     = 7;   // vertex count width
  localparam int CAP_W      = 16;  // arc capacity / residual width
  localparam int FLOW_W     = 32;  // flow accumulator width
  localparam int LVL_W      = 7;   // BFS level width
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [LVL_W-1:0] NO_LEVEL = '1;  // level of an unreached vertex

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_MAX_ARCS     = 128;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_VERTEX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SINK_VERTEX   = 2'd2;

  // Input item kinds
  localparam logic KIND_ADD     = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [VIDX_W-1:0] from_vertex;
    logic [VIDX_W-1:0] to_vertex;
    logic [CAP_W-1:0]  capacity;
  } in_item_t;

  typedef struct packed {
    logic [FLOW_W-1:0] added_flow;
    logic [VIDX_W-1:0] vertex_index;
    logic              sink_side;
    logic              arc_overflow;
    logic              last;
  } out_item_t;

  // One saved frame of the blocking-flow walk
  typedef struct packed {
    logic [VIDX_W-1:0] vertex;
    logic [FLOW_W-1:0] budget;
    logic [FLOW_W-1:0] got;
  } stk_frame_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADD0, ST_ADD1, ST_ADD2, ST_ADD3,
    ST_INIT_RD, ST_INIT_WR,
    ST_BFS_SEED, ST_BFS_POP, ST_BFS_V, ST_BFS_A, ST_BFS_ARC, ST_BFS_CHK,
    ST_DFS_TOP, ST_DFS_CUR, ST_DFS_SCAN, ST_DFS_ARC, ST_DFS_CHK,
    ST_RET0, ST_RET1, ST_RET2, ST_RET3, ST_RET4,
    ST_OUT_RD, ST_OUT_LD, ST_OUT_WAIT
  } state_t;

endpackage

### rtl/dinic_max_flow_min_cut.sv
// dinic_max_flow_min_cut: residual-graph max flow (level BFS + blocking walk).
// Single sequencer over on-chip arc, vertex, queue and stack memories.
// Depends on dmf_pkg.
//
// Usage:
//  - Input channel (in_valid/in_stall/in_data): kind ADD stores one arc as a
//    forward/reverse pair (no result). kind COMPUTE runs phases until
//    no augmenting path is left, then emits one result per vertex in use.
//  - in_stall is high whenever the sequencer is busy; one item at a time.
//  - Compute time is set by the graph walk: each phase sweeps all vertex slots,
//    then the BFS scans vertices and arcs, and the blocking walk scans arcs,
//    pushes frames and pops them. All memory ports are single read /
//    single write.
//  - Result channel (out_valid/out_stall/out_data): one vertex item at a time,
//    in index order; last marks vertex n-1. A stalled result holds in its
//    output register and the sequencer waits on it.
//  - Config port (cfg_we/cfg_idx/cfg_wdata): write only while idle.
//  - Reset (rst_n low, synchronous): empty arc store, overflow flag clear,
//    registers back to count 64, source 0, sink 1. No clearing pass needed.
module dinic_max_flow_min_cut #(
  parameter int MAX_VERTICES = dmf_pkg::DEF_MAX_VERTICES,
  parameter int MAX_ARCS     = dmf_pkg::DEF_MAX_ARCS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dmf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dmf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  dmf_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output dmf_pkg::out_item_t             out_data
);
  import dmf_pkg::*;

  localparam int ARC_SLOTS = 2 * MAX_ARCS + 2;
  localparam int SW  = $clog2(ARC_SLOTS);        // arc slot index
  localparam int UW  = $clog2(MAX_ARCS + 1);     // arcs used count
  localparam int VAW = $clog2(MAX_VERTICES);     // vertex memory address
  localparam int DW  = $clog2(MAX_VERTICES + 1); // depth / queue pointers

  // Config registers
  logic [NCNT_W-1:0] vcount_r;
  logic [VIDX_W-1:0] src_r, sink_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= NCNT_W'(64);
      src_r    <= '0;
      sink_r   <= VIDX_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_VERTEX_COUNT:  vcount_r <= cfg_wdata;
        CFG_SOURCE_VERTEX: src_r    <= cfg_wdata[VIDX_W-1:0];
        CFG_SINK_VERTEX:   sink_r   <= cfg_wdata[VIDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Vertices in use, clamped
  logic [NCNT_W-1:0] n_c;
  always_comb begin
    if (vcount_r < NCNT_W'(2))                 n_c = NCNT_W'(2);
    else if (vcount_r > NCNT_W'(MAX_VERTICES)) n_c = NCNT_W'(MAX_VERTICES);
    else                                       n_c = vcount_r;
  end

  // Memory control
  logic              arc_re, arc_we_full, arc_we_res;
  logic [SW-1:0]     arc_raddr, arc_waddr, arc_link_wd;
  logic [VIDX_W-1:0] arc_head_wd;
  logic [CAP_W-1:0]  arc_res_wd;
  logic [VIDX_W-1:0] head_q;
  logic [CAP_W-1:0]  res_q;
  logic [SW-1:0]     link_q;

  logic              vx_re, cur_we, lvl_we, first_we;
  logic [VIDX_W-1:0] vx_raddr, vx_waddr, first_waddr;
  logic [SW-1:0]     cur_wd, first_wd;
  logic [LVL_W-1:0]  lvl_wd;
  logic [SW-1:0]     cur_q, first_q, first_rd;
  logic              first_vld_q;
  logic [LVL_W-1:0]  lvl_q;

  logic              q_re, q_we;
  logic [DW-1:0]     q_raddr, q_waddr;
  logic [VIDX_W-1:0] q_wd, q_q;

  logic              stk_re, stk_we;
  logic [DW-1:0]     stk_raddr, stk_waddr;
  stk_frame_t        stk_wd, stk_q;

  // Arc store: head, residual, next link
  logic [VIDX_W-1:0] arc_head_mem [ARC_SLOTS];
  logic [CAP_W-1:0]  arc_res_mem  [ARC_SLOTS];
  logic [SW-1:0]     arc_link_mem [ARC_SLOTS];

  always_ff @(posedge clk) begin
    if (arc_we_full) begin
      arc_head_mem[arc_waddr] <= arc_head_wd;
      arc_link_mem[arc_waddr] <= arc_link_wd;
    end
    if (arc_we_full || arc_we_res) arc_res_mem[arc_waddr] <= arc_res_wd;
    if (arc_re) begin
      head_q <= arc_head_mem[arc_raddr];
      res_q  <= arc_res_mem[arc_raddr];
      link_q <= arc_link_mem[arc_raddr];
    end
  end

  // Vertex tables: first arc (with valid bits), current arc, level
  logic [SW-1:0]    first_mem [MAX_VERTICES];
  logic [SW-1:0]    cur_mem   [MAX_VERTICES];
  logic [LVL_W-1:0] lvl_mem   [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] first_vld_r;

  always_ff @(posedge clk) begin
    if (first_we) first_mem[first_waddr[VAW-1:0]] <= first_wd;
    if (cur_we)   cur_mem[vx_waddr[VAW-1:0]]      <= cur_wd;
    if (lvl_we)   lvl_mem[vx_waddr[VAW-1:0]]      <= lvl_wd;
    if (vx_re) begin
      first_q     <= first_mem[vx_raddr[VAW-1:0]];
      first_vld_q <= first_vld_r[vx_raddr[VAW-1:0]];
      cur_q       <= cur_mem[vx_raddr[VAW-1:0]];
      lvl_q       <= lvl_mem[vx_raddr[VAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)        first_vld_r <= '0;
    else if (first_we) first_vld_r[first_waddr[VAW-1:0]] <= 1'b1;
  end

  assign first_rd = first_vld_q ? first_q : '0;

  // BFS queue
  logic [VIDX_W-1:0] q_mem [MAX_VERTICES];
  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_waddr[VAW-1:0]] <= q_wd;
    if (q_re) q_q <= q_mem[q_raddr[VAW-1:0]];
  end

  // Walk stack
  stk_frame_t stk_mem [MAX_VERTICES + 1];
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wd;
    if (stk_re) stk_q <= stk_mem[stk_raddr];
  end

  // Sequencer registers
  state_t            state_r, state_nxt;
  in_item_t          in_r, in_nxt;
  logic [VIDX_W-1:0] v_r, v_nxt;
  logic [SW-1:0]     a_r, a_nxt, lnk_r, lnk_nxt;
  logic [LVL_W-1:0]  lv_r, lv_nxt;
  logic [DW-1:0]     d_r, d_nxt, qh_r, qh_nxt, qt_r, qt_nxt, i_r, i_nxt;
  logic [FLOW_W-1:0] bud_r, bud_nxt, got_r, got_nxt, df_r, df_nxt;
  logic [FLOW_W-1:0] total_r, total_nxt;
  logic [UW-1:0]     used_r, used_nxt;
  logic              ovf_r, ovf_nxt, out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic [SW-1:0]     slot_c;
  logic [FLOW_W-1:0] bud_sub_c, res_ext_c;
  logic              h_in_use_c;

  assign slot_c     = SW'({used_r, 1'b0}) + SW'(2);
  assign bud_sub_c  = bud_r - df_r;
  assign res_ext_c  = FLOW_W'(res_q);
  assign h_in_use_c = {1'b0, head_q} < n_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r    <= in_nxt;
    v_r     <= v_nxt;
    a_r     <= a_nxt;
    lnk_r   <= lnk_nxt;
    lv_r    <= lv_nxt;
    d_r     <= d_nxt;
    qh_r    <= qh_nxt;
    qt_r    <= qt_nxt;
    i_r     <= i_nxt;
    bud_r   <= bud_nxt;
    got_r   <= got_nxt;
    df_r    <= df_nxt;
    total_r <= total_nxt;
    out_r   <= out_nxt;
  end

  // Next state and memory control
  always_comb begin
    state_nxt = state_r;
    in_nxt = in_r; v_nxt = v_r; a_nxt = a_r; lnk_nxt = lnk_r; lv_nxt = lv_r;
    d_nxt = d_r; qh_nxt = qh_r; qt_nxt = qt_r; i_nxt = i_r;
    bud_nxt = bud_r; got_nxt = got_r; df_nxt = df_r; total_nxt = total_r;
    used_nxt = used_r; ovf_nxt = ovf_r;
    out_valid_nxt = out_valid_r; out_nxt = out_r;

    arc_re = 1'b0; arc_raddr = a_r;
    arc_we_full = 1'b0; arc_we_res = 1'b0; arc_waddr = a_r;
    arc_head_wd = in_r.to_vertex; arc_res_wd = in_r.capacity; arc_link_wd = first_rd;
    vx_re = 1'b0; vx_raddr = v_r;
    cur_we = 1'b0; lvl_we = 1'b0; vx_waddr = v_r;
    cur_wd = '0; lvl_wd = NO_LEVEL;
    first_we = 1'b0; first_waddr = in_r.from_vertex; first_wd = slot_c;
    q_re = 1'b0; q_raddr = qh_r; q_we = 1'b0; q_waddr = qt_r; q_wd = head_q;
    stk_re = 1'b0; stk_raddr = d_r - DW'(1);
    stk_we = 1'b0; stk_waddr = d_r;
    stk_wd = '{vertex: v_r, budget: bud_r, got: got_r};

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          in_nxt = in_data;
          if (in_data.kind == KIND_COMPUTE) begin
            total_nxt = '0;
            i_nxt     = '0;
            state_nxt = ST_INIT_RD;
          end else begin
            state_nxt = ST_ADD0;
          end
        end
      end

      // Arc insert: forward slot, then reverse slot
      ST_ADD0: begin
        if (in_r.capacity == '0 || {1'b0, in_r.from_vertex} >= n_c ||
            {1'b0, in_r.to_vertex} >= n_c) begin
          state_nxt = ST_IDLE;
        end else if (used_r == UW'(MAX_ARCS)) begin
          ovf_nxt   = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          vx_re     = 1'b1;
          vx_raddr  = in_r.from_vertex;
          state_nxt = ST_ADD1;
        end
      end
      ST_ADD1: begin
        arc_we_full = 1'b1;
        arc_waddr   = slot_c;
        first_we    = 1'b1;
        state_nxt   = ST_ADD2;
      end
      ST_ADD2: begin
        vx_re     = 1'b1;
        vx_raddr  = in_r.to_vertex;
        state_nxt = ST_ADD3;
      end
      ST_ADD3: begin
        arc_we_full = 1'b1;
        arc_waddr   = slot_c + SW'(1);
        arc_head_wd = in_r.from_vertex;
        arc_res_wd  = '0;
        first_we    = 1'b1;
        first_waddr = in_r.to_vertex;
        first_wd    = slot_c + SW'(1);
        used_nxt    = used_r + UW'(1);
        state_nxt   = ST_IDLE;
      end

      // Phase start: clear levels, rewind current arcs
      ST_INIT_RD: begin
        vx_re     = 1'b1;
        vx_raddr  = VIDX_W'(i_r);
        state_nxt = ST_INIT_WR;
      end
      ST_INIT_WR: begin
        cur_we   = 1'b1;
        lvl_we   = 1'b1;
        vx_waddr = VIDX_W'(i_r);
        cur_wd   = first_rd;
        if (i_r == DW'(MAX_VERTICES - 1)) begin
          i_nxt     = '0;
          state_nxt = ST_BFS_SEED;
        end else begin
          i_nxt     = i_r + DW'(1);
          state_nxt = ST_INIT_RD;
        end
      end

      // Level BFS
      ST_BFS_SEED: begin
        if ({1'b0, src_r} >= n_c) begin
          state_nxt = ST_OUT_RD;
        end else begin
          lvl_we    = 1'b1;
          vx_waddr  = src_r;
          lvl_wd    = '0;
          q_we      = 1'b1;
          q_waddr   = '0;
          q_wd      = src_r;
          qh_nxt    = '0;
          qt_nxt    = DW'(1);
          state_nxt = ST_BFS_POP;
        end
      end
      ST_BFS_POP: begin
        if (qh_r < qt_r) begin
          q_re      = 1'b1;
          qh_nxt    = qh_r + DW'(1);
          state_nxt = ST_BFS_V;
        end else begin
          state_nxt = ST_OUT_RD;
        end
      end
      ST_BFS_V: begin
        vx_re     = 1'b1;
        vx_raddr  = q_q;
        state_nxt = ST_BFS_A;
      end
      ST_BFS_A: begin
        lv_nxt = lvl_q;
        if (first_rd == '0) begin
          state_nxt = ST_BFS_POP;
        end else begin
          arc_re    = 1'b1;
          arc_raddr = first_rd;
          state_nxt = ST_BFS_ARC;
        end
      end
      ST_BFS_ARC: begin
        vx_re     = 1'b1;
        vx_raddr  = head_q;
        state_nxt = ST_BFS_CHK;
      end
      ST_BFS_CHK: begin
        if (res_q != '0 && h_in_use_c && lvl_q == NO_LEVEL) begin
          lvl_we   = 1'b1;
          vx_waddr = head_q;
          lvl_wd   = lv_r + LVL_W'(1);
          if (qt_r < DW'(MAX_VERTICES)) begin
            q_we   = 1'b1;
            qt_nxt = qt_r + DW'(1);
          end
        end
        if (res_q != '0 && h_in_use_c && lvl_q == NO_LEVEL && head_q == sink_r) begin
          // sink reached: start the blocking walk
          d_nxt     = '0;
          v_nxt     = src_r;
          bud_nxt   = '1;
          got_nxt   = '0;
          state_nxt = ST_DFS_TOP;
        end else if (link_q == '0) begin
          state_nxt = ST_BFS_POP;
        end else begin
          arc_re    = 1'b1;
          arc_raddr = link_q;
          state_nxt = ST_BFS_ARC;
        end
      end

      // Blocking walk, advance side
      ST_DFS_TOP: begin
        if (v_r == sink_r) begin
          df_nxt    = bud_r;
          state_nxt = ST_RET0;
        end else begin
          vx_re     = 1'b1;
          state_nxt = ST_DFS_CUR;
        end
      end
      ST_DFS_CUR: begin
        a_nxt     = cur_q;
        lv_nxt    = lvl_q;
        state_nxt = ST_DFS_SCAN;
      end
      ST_DFS_SCAN: begin
        if (a_r == '0) begin
          // dead end: retire the vertex
          cur_we    = 1'b1;
          lvl_we    = 1'b1;
          df_nxt    = got_r;
          state_nxt = ST_RET0;
        end else begin
          arc_re    = 1'b1;
          state_nxt = ST_DFS_ARC;
        end
      end
      ST_DFS_ARC: begin
        vx_re     = 1'b1;
        vx_raddr  = head_q;
        state_nxt = ST_DFS_CHK;
      end
      ST_DFS_CHK: begin
        if (res_q != '0 && h_in_use_c && lvl_q == LVL_W'(lv_r + LVL_W'(1)) &&
            d_r < DW'(MAX_VERTICES)) begin
          stk_we    = 1'b1;
          d_nxt     = d_r + DW'(1);
          v_nxt     = head_q;
          bud_nxt   = (bud_r < res_ext_c) ? bud_r : res_ext_c;
          got_nxt   = '0;
          state_nxt = ST_DFS_TOP;
        end else begin
          a_nxt     = link_q;
          cur_we    = 1'b1;
          cur_wd    = link_q;
          state_nxt = ST_DFS_SCAN;
        end
      end

      // Blocking walk, return side
      ST_RET0: begin
        if (d_r == '0) begin
          total_nxt = total_r + df_r;
          i_nxt     = '0;
          state_nxt = ST_INIT_RD;
        end else begin
          stk_re    = 1'b1;
          d_nxt     = d_r - DW'(1);
          state_nxt = ST_RET1;
        end
      end
      ST_RET1: begin
        v_nxt     = stk_q.vertex;
        bud_nxt   = stk_q.budget;
        got_nxt   = stk_q.got;
        vx_re     = 1'b1;
        vx_raddr  = stk_q.vertex;
        state_nxt = ST_RET2;
      end
      ST_RET2: begin
        a_nxt     = cur_q;
        arc_re    = 1'b1;
        arc_raddr = cur_q;
        state_nxt = ST_RET3;
      end
      ST_RET3: begin
        lnk_nxt = link_q;
        if (df_r != '0) begin
          arc_we_res = 1'b1;
          arc_res_wd = res_q - df_r[CAP_W-1:0];
          got_nxt    = got_r + df_r;
          arc_re     = 1'b1;
          arc_raddr  = a_r ^ SW'(1);
          state_nxt  = ST_RET4;
        end else begin
          cur_we    = 1'b1;
          cur_wd    = link_q;
          state_nxt = ST_DFS_TOP;
        end
      end
      ST_RET4: begin
        arc_we_res = 1'b1;
        arc_waddr  = a_r ^ SW'(1);
        arc_res_wd = res_q + df_r[CAP_W-1:0];
        bud_nxt    = bud_sub_c;
        if (bud_sub_c == '0) begin
          df_nxt    = got_r;
          state_nxt = ST_RET0;
        end else begin
          cur_we    = 1'b1;
          cur_wd    = lnk_r;
          state_nxt = ST_DFS_TOP;
        end
      end

      // Per-vertex results
      ST_OUT_RD: begin
        vx_re     = 1'b1;
        vx_raddr  = VIDX_W'(i_r);
        state_nxt = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        out_nxt.added_flow   = total_r;
        out_nxt.vertex_index = VIDX_W'(i_r);
        out_nxt.sink_side    = (lvl_q == NO_LEVEL);
        out_nxt.arc_overflow = ovf_r;
        out_nxt.last         = (NCNT_W'(i_r) + NCNT_W'(1) == n_c);
        out_valid_nxt        = 1'b1;
        state_nxt            = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          i_nxt         = i_r + DW'(1);
          state_nxt     = out_r.last ? ST_IDLE : ST_OUT_RD;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_no_input_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DFS_TOP) |-> (d_r <= DW'(MAX_VERTICES)))
    else $error("walk stack depth out of range");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.last) |=> (!out_valid && state_r == ST_IDLE))
    else $error("run did not end after last result");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(MAX_ARCS))
    else $error("arc count beyond store size");

endmodule

### tb/dmf_checker.sv
// dmf_checker: watches the config port and both channels of the max-flow
// block, keeps its own residual graph and predicts every vertex result.
// Depends on dmf_pkg.
module dmf_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dmf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dmf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  dmf_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  dmf_pkg::out_item_t             out_data,
  output int                             errors,
  output int                             pending,
  output int                             checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import dmf_pkg::*;

  localparam int NV        = DEF_MAX_VERTICES;
  localparam int NARC      = DEF_MAX_ARCS;
  localparam int SLOTS     = 2 * NARC + 2;
  localparam int EXP_DEPTH = 128;

  // configuration copy
  int unsigned vcount_r, src_r, snk_r;

  // residual graph
  logic [5:0]  arc_to   [SLOTS];
  logic [15:0] arc_res  [SLOTS];
  logic [8:0]  arc_next [SLOTS];
  logic [8:0]  first_of [NV];
  logic [8:0]  cur_of   [NV];
  int          level_of [NV];
  logic [5:0]  bfs_q    [NV];
  int unsigned pairs_stored;
  logic        dropped_flag;

  // walk stack
  int unsigned stk_v   [NV+1];
  logic [31:0] stk_bud [NV+1];
  logic [31:0] stk_got [NV+1];

  // expected results, oldest first
  out_item_t   exp_mem [EXP_DEPTH];
  int unsigned exp_wr, exp_rd;

  function automatic int unsigned vertices_in_use();
    if (vcount_r < 2) return 2;
    if (vcount_r > NV) return NV;
    return vcount_r;
  endfunction

  function automatic void store_arc(int unsigned slot, int unsigned tl,
                                    int unsigned hd, logic [15:0] cap);
    arc_to[slot]   = hd[5:0];
    arc_res[slot]  = cap;
    arc_next[slot] = first_of[tl];
    first_of[tl]   = slot[8:0];
  endfunction

  // level BFS, stops once the sink has a level
  function automatic bit build_levels(int unsigned n);
    int unsigned qh, qt, v, a, h;
    qh = 0;
    qt = 0;
    for (int i = 0; i < NV; i++) begin
      level_of[i] = -1;
      cur_of[i]   = first_of[i];
    end
    if (src_r >= n) return 0;
    level_of[src_r] = 0;
    bfs_q[qt] = src_r[5:0];
    qt++;
    while (qh < qt) begin
      v = bfs_q[qh];
      qh++;
      a = first_of[v];
      while (a != 0 && a < SLOTS) begin
        h = arc_to[a];
        if (arc_res[a] != 0 && h < n && level_of[h] == -1) begin
          level_of[h] = level_of[v] + 1;
          if (qt < NV) begin
            bfs_q[qt] = h[5:0];
            qt++;
          end
          if (h == snk_r) return 1;
        end
        a = arc_next[a];
      end
    end
    return 0;
  endfunction

  // blocking flow over the level graph with current-arc pointers
  function automatic logic [31:0] push_blocking(int unsigned n);
    int unsigned d, v, a, h;
    logic [31:0] df, want;
    bit have;
    d = 0;
    have = 0;
    stk_v[0] = src_r;
    stk_bud[0] = '1;
    stk_got[0] = 0;
    forever begin
      df = 0;
      v = stk_v[d];
      if (v == snk_r) begin
        df = stk_bud[d];
        have = 1;
      end else begin
        a = cur_of[v];
        while (a != 0 && a < SLOTS) begin
          h = arc_to[a];
          if (arc_res[a] != 0 && h < n && level_of[h] == level_of[v] + 1 && d < NV) begin
            want = (stk_bud[d] < 32'(arc_res[a])) ? stk_bud[d] : 32'(arc_res[a]);
            d++;
            stk_v[d] = h;
            stk_bud[d] = want;
            stk_got[d] = 0;
            break;
          end
          a = arc_next[a];
          cur_of[v] = a[8:0];
        end
        if (stk_v[d] != v || (a != 0 && a < SLOTS)) continue;
        // dead end: retire this vertex from the level graph
        cur_of[v] = 0;
        level_of[v] = -1;
        df = stk_got[d];
        have = 1;
      end
      // hand flow back to parents while they finish
      while (have) begin
        have = 0;
        if (d == 0) return df;
        d--;
        v = stk_v[d];
        a = cur_of[v];
        if (df != 0) begin
          stk_got[d] += df;
          arc_res[a] = arc_res[a] - df[15:0];
          arc_res[a ^ 1] = arc_res[a ^ 1] + df[15:0];
          stk_bud[d] -= df;
          if (stk_bud[d] == 0) begin
            df = stk_got[d];
            have = 1;
            continue;
          end
        end
        cur_of[v] = arc_next[a];
      end
    end
  endfunction

  function automatic void predict_item(in_item_t it);
    int unsigned n;
    logic [31:0] total;
    out_item_t r;
    n = vertices_in_use();
    total = 0;
    if (it.kind == KIND_ADD) begin
      if (it.capacity == 0 || it.from_vertex >= n || it.to_vertex >= n) return;
      if (pairs_stored >= NARC) begin
        dropped_flag = 1;
        return;
      end
      store_arc(2 * pairs_stored + 2, it.from_vertex, it.to_vertex, it.capacity);
      store_arc(2 * pairs_stored + 3, it.to_vertex, it.from_vertex, 16'd0);
      pairs_stored++;
      return;
    end
    while (build_levels(n)) total += push_blocking(n);
    for (int unsigned i = 0; i < n; i++) begin
      r.added_flow   = total;
      r.vertex_index = i[5:0];
      r.sink_side    = (level_of[i] == -1);
      r.arc_overflow = dropped_flag;
      r.last         = (i + 1 == n);
      exp_mem[exp_wr % EXP_DEPTH] = r;
      exp_wr++;
    end
  endfunction

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // watch config writes and both channel transfers
  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      vcount_r = 64;
      src_r = 0;
      snk_r = 1;
      for (int i = 0; i < NV; i++) begin
        first_of[i] = 0;
        cur_of[i] = 0;
        level_of[i] = -1;
      end
      pairs_stored = 0;
      dropped_flag = 0;
      exp_wr = 0;
      exp_rd = 0;
      errors = 0;
      checked = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_VERTEX_COUNT:  vcount_r = cfg_wdata;
          CFG_SOURCE_VERTEX: src_r = cfg_wdata[5:0];
          CFG_SINK_VERTEX:   snk_r = cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_item(in_data);
      if (out_valid && !out_stall) begin
        checked++;
        if (exp_wr == exp_rd) begin
          report($sformatf("unexpected result for vertex %0d", out_data.vertex_index));
        end else begin
          e = exp_mem[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (out_data.added_flow !== e.added_flow)
            report($sformatf("v%0d added_flow %0d exp %0d", e.vertex_index,
                             out_data.added_flow, e.added_flow));
          if (out_data.vertex_index !== e.vertex_index)
            report($sformatf("vertex_index %0d exp %0d", out_data.vertex_index,
                             e.vertex_index));
          if (out_data.sink_side !== e.sink_side)
            report($sformatf("v%0d sink_side %b exp %b", e.vertex_index,
                             out_data.sink_side, e.sink_side));
          if (out_data.arc_overflow !== e.arc_overflow)
            report($sformatf("v%0d arc_overflow %b exp %b", e.vertex_index,
                             out_data.arc_overflow, e.arc_overflow));
          if (out_data.last !== e.last)
            report($sformatf("v%0d last %b exp %b", e.vertex_index, out_data.last, e.last));
        end
      end
    end
    pending = int'(exp_wr - exp_rd);
  end

endmodule

### tb/tb_top.sv
// tb_top: stimulus and verdict for dinic_max_flow_min_cut: directed graphs
// and random graph phases. Depends on dmf_pkg, dmf_checker and the block
// itself.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dmf_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid, in_stall, out_valid;
  logic out_stall = 1'b0;
  in_item_t  in_data;
  out_item_t out_data;
  int errors, pending, checked;

  logic in_took, out_took, calm;
  int   hold_cnt = 0;
  int   cycles = 0;
  int   n_adds, n_runs, sent;

  dinic_max_flow_min_cut i_dut (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_wdata,
    .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  dmf_checker i_chk (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_wdata,
    .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .errors, .pending, .checked
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // transfer flags, read back at the falling edge
  always @(posedge clk) begin
    in_took  <= in_valid && !in_stall;
    out_took <= out_valid && !out_stall;
  end

  // receiver: random stall after each transfer, none in calm phases
  always @(negedge clk) begin
    if (out_took) hold_cnt = calm ? 0 : $urandom_range(0, 3);
    out_stall <= (hold_cnt != 0);
    if (hold_cnt != 0) hold_cnt--;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // wait until all results are in and an add has had time to land
  task automatic settle();
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0 || in_stall) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic send(logic kind, int fv, int tv, int cap);
    int gap;
    in_item_t it;
    gap = calm ? 0 : $urandom_range(0, 3);
    it.kind = kind;
    it.from_vertex = fv[5:0];
    it.to_vertex = tv[5:0];
    it.capacity = cap[15:0];
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(negedge clk); while (!in_took);
    sent++;
    if (kind == KIND_ADD) n_adds++;
    else n_runs++;
  endtask

  task automatic add_arc(int fv, int tv, int cap);
    send(KIND_ADD, fv, tv, cap);
  endtask

  task automatic run_compute();
    send(KIND_COMPUTE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 65535));
  endtask

  task automatic set_graph(int n, int s, int t);
    settle();
    cfg_write(CFG_VERTEX_COUNT, n[6:0]);
    cfg_write(CFG_SOURCE_VERTEX, s[6:0]);
    cfg_write(CFG_SINK_VERTEX, t[6:0]);
  endtask

  initial begin
    int n, k;
    rst_n = 0;
    cfg_we = 0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_valid = 0;
    in_data = '0;
    calm = 0;
    n_adds = 0;
    n_runs = 0;
    sent = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: reset settings, extreme capacities and vertices
    add_arc(0, 1, 65535);
    add_arc(0, 2, 0);          // zero capacity, ignored
    add_arc(63, 1, 1);         // arc from vertex 63 into the sink
    add_arc(0, 63, 1);
    add_arc(63, 63, 7);        // self loop
    run_compute();
    // count below range acts as two; arc already saturated
    set_graph(1, 0, 1);
    run_compute();
    set_graph(0, 0, 1);
    run_compute();
    // count above range acts as 64, source 63 sink 0
    set_graph(127, 63, 0);
    add_arc(63, 0, 100);
    run_compute();
    // source out of use
    set_graph(4, 5, 1);
    add_arc(10, 2, 5);         // tail out of use, ignored
    add_arc(2, 40, 5);         // head out of use, ignored
    run_compute();
    // sink equal to source
    set_graph(8, 3, 3);
    add_arc(3, 4, 9);
    run_compute();
    // sink out of use, and arcs to dropped vertices
    set_graph(2, 0, 9);
    run_compute();
    settle();
    cfg_write(2'd3, 7'h7f);    // unmapped index

    // random graph phases
    while (sent < 95) begin
      n = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(2, 12);
      if ($urandom_range(0, 7) == 0) set_graph($urandom_range(0, 127), $urandom_range(0, 63),
                                               $urandom_range(0, 63));
      else set_graph(n, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
      calm = ($urandom_range(0, 3) == 0);
      k = $urandom_range(3, 10);
      repeat (k) begin
        int cap;
        case ($urandom_range(0, 9))
          0: cap = 0;
          1, 2: cap = $urandom_range(0, 65535);
          default: cap = $urandom_range(1, 20);
        endcase
        if ($urandom_range(0, 9) == 0)
          add_arc($urandom_range(0, 63), $urandom_range(0, 63), cap);
        else
          add_arc($urandom_range(0, n - 1), $urandom_range(0, n - 1), cap);
      end
      run_compute();
    end

    settle();
    repeat (40) @(negedge clk);
    $display("covered %0d arc loads and %0d compute runs, %0d vertex results checked",
             n_adds, n_runs, checked);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### dinic_max_flow_min_cut.f
rtl/dmf_pkg.sv
rtl/dinic_max_flow_min_cut.sv
tb/dmf_checker.sv
tb/tb_top.sv
